@@ hdl/bfsp_pkg.sv @@
package bfsp_pkg;

  // Default configuration
  localparam int VERTICES_DEF    = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int INF_DEF         = 2147483647;

  // Fixed field widths
  localparam int VID_W  = 4;
  localparam int WIN_W  = 16;
  localparam int DIST_W = 32;
  localparam int PRED_W = 5;

  // Operation codes
  localparam logic [1:0] OP_ADD_EDGE   = 2'd0;
  localparam logic [1:0] OP_ADD_VERTEX = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  // Predecessor code for the source or no predecessor
  localparam logic signed [PRED_W-1:0] PRED_NONE = -5'sd1;

  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic signed [PRED_W-1:0] pred_t;

  // Outcome of one arc relaxation
  typedef struct packed {
    logic  better;
    dist_t sum;
  } relax_t;

endpackage

@@ hdl/bellman_ford_shortest_paths_core.sv @@
// Bellman-Ford single-source shortest paths over a small weighted digraph.
// Input stream: s_axis_tuser carries the operation, s_axis_tdata carries the
// vertices and the arc weight. Add-edge and add-vertex transactions produce
// nothing. A compute transaction runs VERTICES-1 passes over all tail/head
// pairs through one shared add/saturate/compare unit. In each pass a present
// tail with a finite distance gets a distance read, then a weight/distance
// read and relax per head; absent or unreached tails are skipped. Set-up
// seeds every distance and the final scan reads each vertex; the input is
// not ready meanwhile.
// Output stream: one transaction per reached present vertex in ascending
// order, tlast on the final one; tuser flags the empty answer (source absent
// or without outgoing arc), which is a single transaction.
// Results sit in an output register; a stalled receiver holds the scan until
// the register drains, nothing is dropped.
// After reset the weight memory is cleared, one entry per cycle, all
// 2**(2*clog2(VERTICES)) entries (256 at 16 vertices), before the input is ready.
module bellman_ford_shortest_paths_core #(
  parameter int VERTICES    = bfsp_pkg::VERTICES_DEF,
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF,
  parameter int INF         = bfsp_pkg::INF_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // from_vertex[3:0], to_vertex[7:4], arc_weight[23:8]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // vertex_id[3:0], distance[35:4], predecessor[40:36]
  output logic        m_axis_tuser,  // empty_answer[0]
  output logic        m_axis_tlast
);
  import bfsp_pkg::*;

  localparam int VW     = $clog2(VERTICES);
  localparam int AW     = 2 * VW;
  localparam int WDEPTH = 1 << AW;
  localparam int SW     = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

  localparam logic [VW-1:0] IDX_LAST  = VW'(VERTICES - 1);
  localparam logic [VW-1:0] PASS_LAST = VW'(VERTICES - 2);
  localparam dist_t         INF_D     = 32'(INF);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_INIT, ST_TAIL, ST_TAILW,
    ST_HEAD, ST_RELAX, ST_SCAN, ST_SCANW, ST_FLUSH
  } state_e;

  state_e state_q;

  // Storage
  logic signed [SW-1:0] weight_mem [WDEPTH];
  dist_t                dist_mem [VERTICES];
  pred_t                pred_mem [VERTICES];
  logic signed [SW-1:0] w_rd_q;
  dist_t                d_rd_q;
  pred_t                p_rd_q;

  logic [VERTICES-1:0] present_q;
  logic [VERTICES-1:0] row_arc_q;

  // Sequencer registers
  logic [AW-1:0] clr_q;
  logic [VW-1:0] src_q, i_q, j_q, k_q, pass_q;
  dist_t         dist_i_q;

  // Pending and output results
  logic          pend_valid_q, pend_empty_q;
  logic [VID_W-1:0] pend_vid_q, out_vid_q;
  dist_t         pend_dist_q, out_dist_q;
  pred_t         pend_pred_q, out_pred_q;
  logic          out_valid_q, out_empty_q, out_last_q;

  // Input decode
  logic [1:0]       op_in;
  logic [VID_W-1:0] from_v, to_v;
  logic [WIN_W-1:0] w_in;
  logic [VW-1:0]    from_idx, to_idx;
  logic             from_ok, to_ok, edge_ok, has_arc, in_fire;
  logic signed [SW-1:0] w_red;

  assign op_in    = s_axis_tuser;
  assign from_v   = s_axis_tdata[3:0];
  assign to_v     = s_axis_tdata[7:4];
  assign w_in     = s_axis_tdata[23:8];
  assign from_idx = VW'(from_v);
  assign to_idx   = VW'(to_v);
  assign from_ok  = int'(from_v) < VERTICES;
  assign to_ok    = int'(to_v) < VERTICES;
  assign w_red    = w_in[SW-1:0];
  assign edge_ok  = from_ok && to_ok && (|w_red);
  assign has_arc  = from_ok && present_q[from_idx] && row_arc_q[from_idx];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Shared relaxation unit
  relax_t relax;

  bfsp_relax #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .INF         (INF),
    .SW          (SW)
  ) u_relax (
    .dist_tail_i (dist_i_q),
    .weight_i    (w_rd_q),
    .dist_head_i (d_rd_q),
    .relax_o     (relax)
  );

  // Distance store read address follows the sequencer step
  logic [VW-1:0] rd_idx;

  always_comb begin
    case (state_q)
      ST_HEAD:           rd_idx = j_q;
      ST_SCAN, ST_SCANW: rd_idx = k_q;
      default:           rd_idx = i_q;
    endcase
  end

  // Distance store write port
  logic          d_we;
  logic [VW-1:0] d_waddr;
  dist_t         d_wdist;
  pred_t         d_wpred;

  always_comb begin
    d_we    = 1'b0;
    d_waddr = j_q;
    d_wdist = relax.sum;
    d_wpred = PRED_W'(i_q);
    case (state_q)
      ST_INIT: begin
        d_we    = 1'b1;
        d_waddr = k_q;
        d_wdist = (k_q == src_q) ? '0 : INF_D;
        d_wpred = PRED_NONE;
      end
      ST_RELAX: begin
        d_we = relax.better;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      dist_mem[d_waddr] <= d_wdist;
      pred_mem[d_waddr] <= d_wpred;
    end
    d_rd_q <= dist_mem[rd_idx];
    p_rd_q <= pred_mem[rd_idx];
  end

  // Weight memory: clearing sweep after reset, then arc writes
  logic                 w_we;
  logic [AW-1:0]        w_waddr;
  logic signed [SW-1:0] w_wdata;

  always_comb begin
    w_we    = 1'b0;
    w_waddr = {from_idx, to_idx};
    w_wdata = w_red;
    if (state_q == ST_CLEAR) begin
      w_we    = 1'b1;
      w_waddr = clr_q;
      w_wdata = '0;
    end else if (in_fire && op_in == OP_ADD_EDGE && edge_ok) begin
      w_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      weight_mem[w_waddr] <= w_wdata;
    end
    w_rd_q <= weight_mem[{i_q, j_q}];
  end

  // Step conditions
  logic tail_done, out_free, scan_hit;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign scan_hit  = d_rd_q < INF_D;
  assign tail_done = (state_q == ST_TAIL && !present_q[i_q]) ||
                     (state_q == ST_TAILW && d_rd_q >= INF_D) ||
                     (state_q == ST_RELAX && j_q == IDX_LAST);

  // Sequencer, graph flags and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      present_q    <= '0;
      row_arc_q    <= '0;
      clr_q        <= '0;
      src_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      pass_q       <= '0;
      dist_i_q     <= '0;
      pend_valid_q <= 1'b0;
      pend_empty_q <= 1'b0;
      pend_vid_q   <= '0;
      pend_dist_q  <= '0;
      pend_pred_q  <= '0;
      out_valid_q  <= 1'b0;
      out_empty_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_vid_q    <= '0;
      out_dist_q   <= '0;
      out_pred_q   <= '0;
    end else begin
      // Drop a result once it is taken
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_fire) begin
            case (op_in)
              OP_ADD_EDGE: begin
                if (edge_ok) begin
                  present_q[from_idx] <= 1'b1;
                  present_q[to_idx]   <= 1'b1;
                  row_arc_q[from_idx] <= 1'b1;
                end
              end
              OP_ADD_VERTEX: begin
                if (from_ok) begin
                  present_q[from_idx] <= 1'b1;
                end
              end
              OP_COMPUTE: begin
                if (has_arc) begin
                  src_q   <= from_idx;
                  k_q     <= '0;
                  state_q <= ST_INIT;
                end else begin
                  pend_valid_q <= 1'b1;
                  pend_empty_q <= 1'b1;
                  pend_vid_q   <= '0;
                  pend_dist_q  <= '0;
                  pend_pred_q  <= PRED_NONE;
                  state_q      <= ST_FLUSH;
                end
              end
              default: ;
            endcase
          end
        end

        // Seed distances and predecessors
        ST_INIT: begin
          if (k_q == IDX_LAST) begin
            i_q     <= '0;
            pass_q  <= '0;
            state_q <= ST_TAIL;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end

        ST_TAIL: begin
          if (present_q[i_q]) begin
            state_q <= ST_TAILW;
          end
        end

        ST_TAILW: begin
          dist_i_q <= d_rd_q;
          j_q      <= '0;
          state_q  <= ST_HEAD;
        end

        ST_HEAD: begin
          state_q <= ST_RELAX;
        end

        // Apply one relaxation, follow a self-loop into the tail distance
        ST_RELAX: begin
          if (relax.better && j_q == i_q) begin
            dist_i_q <= relax.sum;
          end
          if (j_q != IDX_LAST) begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_HEAD;
          end
        end

        ST_SCAN: begin
          if (present_q[k_q]) begin
            state_q <= ST_SCANW;
          end else if (k_q == IDX_LAST) begin
            state_q <= ST_FLUSH;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end

        // Hold a found vertex until the previous one is sent
        ST_SCANW: begin
          if (!scan_hit || !pend_valid_q || out_free) begin
            if (scan_hit) begin
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_empty_q <= pend_empty_q;
                out_last_q  <= 1'b0;
                out_vid_q   <= pend_vid_q;
                out_dist_q  <= pend_dist_q;
                out_pred_q  <= pend_pred_q;
              end
              pend_valid_q <= 1'b1;
              pend_empty_q <= 1'b0;
              pend_vid_q   <= VID_W'(k_q);
              pend_dist_q  <= d_rd_q;
              pend_pred_q  <= p_rd_q;
            end
            if (k_q == IDX_LAST) begin
              state_q <= ST_FLUSH;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_SCAN;
            end
          end
        end

        ST_FLUSH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_empty_q  <= pend_empty_q;
            out_last_q   <= 1'b1;
            out_vid_q    <= pend_vid_q;
            out_dist_q   <= pend_dist_q;
            out_pred_q   <= pend_pred_q;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase

      // Advance to the next tail, then the next pass, then the scan
      if (tail_done) begin
        if (i_q == IDX_LAST) begin
          i_q <= '0;
          if (pass_q == PASS_LAST) begin
            k_q     <= '0;
            state_q <= ST_SCAN;
          end else begin
            pass_q  <= pass_q + 1'b1;
            state_q <= ST_TAIL;
          end
        end else begin
          i_q     <= i_q + 1'b1;
          state_q <= ST_TAIL;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_pred_q, out_dist_q, out_vid_q};
  assign m_axis_tuser  = out_empty_q;
  assign m_axis_tlast  = out_last_q;

  // An empty answer is always the only and final transaction
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && out_pred_q == PRED_NONE))
    else $error("empty answer without tlast or with a predecessor");

  // A reported vertex always has a finite distance
  a_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (out_dist_q < INF_D))
    else $error("result with infinite distance");

  // Only reached tails relax their arcs
  a_tail_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEAD || state_q == ST_RELAX) |-> (dist_i_q < INF_D))
    else $error("relaxing from an unreached tail");

  // The result register is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result overwritten");

endmodule

@@ hdl/bfsp_relax.sv @@
module bfsp_relax #(
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF,
  parameter int INF         = bfsp_pkg::INF_DEF,
  parameter int SW          = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16
) (
  input  bfsp_pkg::dist_t   dist_tail_i,
  input  logic signed [SW-1:0] weight_i,
  input  bfsp_pkg::dist_t   dist_head_i,
  output bfsp_pkg::relax_t  relax_o
);
  import bfsp_pkg::*;

  localparam logic signed [DIST_W:0] SUM_MAX = 33'(INF) - 33'sd1;
  localparam logic signed [DIST_W:0] SUM_MIN = 33'sh1_8000_0000;

  logic signed [DIST_W:0] dist_ext;
  logic signed [DIST_W:0] weight_ext;
  logic signed [DIST_W:0] sum;
  dist_t                  sum_sat;

  // Add the arc weight to the tail distance
  assign dist_ext   = 33'(dist_tail_i);
  assign weight_ext = 33'(weight_i);
  assign sum        = dist_ext + weight_ext;

  // Saturate into the finite distance range
  always_comb begin
    if (sum > SUM_MAX) begin
      sum_sat = SUM_MAX[DIST_W-1:0];
    end else if (sum < SUM_MIN) begin
      sum_sat = SUM_MIN[DIST_W-1:0];
    end else begin
      sum_sat = sum[DIST_W-1:0];
    end
  end

  // Relax only a real arc that improves the head
  assign relax_o.better = (|weight_i) && (sum_sat < dist_head_i);
  assign relax_o.sum    = sum_sat;

endmodule
